// File: hw/rtl/tpdc_pkg.sv
// shared types, constants and the control program of the tec pid drive controller
package tpdc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_TARGET_TEMP   = 3'd0;
    localparam logic [2:0] REG_GAIN_P        = 3'd1;
    localparam logic [2:0] REG_GAIN_I        = 3'd2;
    localparam logic [2:0] REG_GAIN_D        = 3'd3;
    localparam logic [2:0] REG_BALANCE_LEVEL = 3'd4;
    localparam logic [2:0] REG_DRIVE_MAX     = 3'd5;
    localparam logic [2:0] REG_DRIVE_MIN     = 3'd6;
    localparam logic [2:0] REG_DEADBAND      = 3'd7;

    // loop limits
    localparam logic signed [16:0] ERR_HI      = 17'sd10000;
    localparam logic signed [16:0] ERR_LO      = -17'sd10000;
    localparam logic signed [20:0] SUM_HI      = 21'sd500000;
    localparam logic signed [20:0] SUM_LO      = -21'sd500000;
    localparam logic [15:0]        DIVERGE_ERR = 16'd6000;
    localparam logic [15:0]        ENABLE_CEIL = 16'd20000;
    localparam logic signed [37:0] TRUNC_BIAS  = 38'sd4095;

    // program steps
    localparam logic [3:0] STEP_WAIT     = 4'd0;
    localparam logic [3:0] STEP_EVAL     = 4'd1;
    localparam logic [3:0] STEP_SKIP     = 4'd2;
    localparam logic [3:0] STEP_BAND     = 4'd3;
    localparam logic [3:0] STEP_DIVERGE  = 4'd4;
    localparam logic [3:0] STEP_INTEG    = 4'd5;
    localparam logic [3:0] STEP_MUL_P    = 4'd6;
    localparam logic [3:0] STEP_MUL_I    = 4'd7;
    localparam logic [3:0] STEP_MUL_D    = 4'd8;
    localparam logic [3:0] STEP_ACC      = 4'd9;
    localparam logic [3:0] STEP_LEVEL    = 4'd10;
    localparam logic [3:0] STEP_CLAMP    = 4'd11;
    localparam logic [3:0] STEP_MUL_S    = 4'd12;
    localparam logic [3:0] STEP_DIV_LOAD = 4'd13;
    localparam logic [3:0] STEP_DIV      = 4'd14;
    localparam logic [3:0] STEP_EMIT     = 4'd15;

    // datapath operations
    localparam logic [3:0] OP_LATCH    = 4'd0;
    localparam logic [3:0] OP_EVAL     = 4'd1;
    localparam logic [3:0] OP_SKIP     = 4'd2;
    localparam logic [3:0] OP_BAND     = 4'd3;
    localparam logic [3:0] OP_DIVERGE  = 4'd4;
    localparam logic [3:0] OP_INTEG    = 4'd5;
    localparam logic [3:0] OP_MUL_P    = 4'd6;
    localparam logic [3:0] OP_MUL_I    = 4'd7;
    localparam logic [3:0] OP_MUL_D    = 4'd8;
    localparam logic [3:0] OP_ACC      = 4'd9;
    localparam logic [3:0] OP_LEVEL    = 4'd10;
    localparam logic [3:0] OP_CLAMP    = 4'd11;
    localparam logic [3:0] OP_MUL_S    = 4'd12;
    localparam logic [3:0] OP_DIV_LOAD = 4'd13;
    localparam logic [3:0] OP_DIV      = 4'd14;
    localparam logic [3:0] OP_EMIT     = 4'd15;

    // jump conditions
    localparam logic [2:0] COND_NONE     = 3'd0;  // next step
    localparam logic [2:0] COND_NO_INPUT = 3'd1;  // jump while no item offered
    localparam logic [2:0] COND_SKIP     = 3'd2;  // jump when tick is skipped
    localparam logic [2:0] COND_INBAND   = 3'd3;  // jump when error inside deadband
    localparam logic [2:0] COND_DIV_BUSY = 3'd4;  // jump while divider has bits left
    localparam logic [2:0] COND_WAIT_OUT = 3'd5;  // hold until output free, then jump

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [3:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input logic [3:0] step);
        ctrl_word_t cw;
        case (step)
            STEP_WAIT:     cw = '{OP_LATCH,    COND_NO_INPUT, STEP_WAIT};
            STEP_EVAL:     cw = '{OP_EVAL,     COND_NONE,     STEP_WAIT};
            STEP_SKIP:     cw = '{OP_SKIP,     COND_SKIP,     STEP_EMIT};
            STEP_BAND:     cw = '{OP_BAND,     COND_INBAND,   STEP_EMIT};
            STEP_DIVERGE:  cw = '{OP_DIVERGE,  COND_NONE,     STEP_WAIT};
            STEP_INTEG:    cw = '{OP_INTEG,    COND_NONE,     STEP_WAIT};
            STEP_MUL_P:    cw = '{OP_MUL_P,    COND_NONE,     STEP_WAIT};
            STEP_MUL_I:    cw = '{OP_MUL_I,    COND_NONE,     STEP_WAIT};
            STEP_MUL_D:    cw = '{OP_MUL_D,    COND_NONE,     STEP_WAIT};
            STEP_ACC:      cw = '{OP_ACC,      COND_NONE,     STEP_WAIT};
            STEP_LEVEL:    cw = '{OP_LEVEL,    COND_NONE,     STEP_WAIT};
            STEP_CLAMP:    cw = '{OP_CLAMP,    COND_NONE,     STEP_WAIT};
            STEP_MUL_S:    cw = '{OP_MUL_S,    COND_NONE,     STEP_WAIT};
            STEP_DIV_LOAD: cw = '{OP_DIV_LOAD, COND_NONE,     STEP_WAIT};
            STEP_DIV:      cw = '{OP_DIV,      COND_DIV_BUSY, STEP_DIV};
            STEP_EMIT:     cw = '{OP_EMIT,     COND_WAIT_OUT, STEP_WAIT};
            default:       cw = '{OP_LATCH,    COND_NO_INPUT, STEP_WAIT};
        endcase
        return cw;
    endfunction

endpackage

// File: hw/rtl/tec_pid_drive_controller.sv
// tec pid drive controller: microcoded pid loop with integral clamp and dac scaling
//
// One input item is one control tick and gives exactly one result item. A small
// program of sixteen steps runs one tick at a time over a shared 17x21 signed
// multiplier and a restoring divider that makes one quotient bit per cycle. A tick
// that is skipped or in the deadband jumps from its skip or deadband step to the
// final step; a full tick runs every step in turn, the divider step repeating for
// each quotient bit. The result sits in an output register, so the next item
// is accepted as soon as the program is back at its first step, and a stalled
// result only holds the program at its final step. Configuration writes are taken
// at any time and should be made while no tick is in flight.
module tec_pid_drive_controller
    import tpdc_pkg::*;
#(
    parameter int DAC_BITS      = 12,
    parameter int DIVERGE_TICKS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // temp_sample[15:0], supply_level[31:16], tx_disabled[32]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // drive_code[11:0], drive_written[12], status[13],
                                   // cooler_enable[14]
);

    localparam int DVD_W   = 16 + DAC_BITS;
    localparam int DCNT_W  = $clog2(DVD_W + 1);
    localparam int CNT_W   = $clog2(DIVERGE_TICKS + 2);
    localparam logic [DAC_BITS-1:0] DAC_FULL = '1;

    // configuration
    logic [15:0] target_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [15:0] balance_reg, drive_max_reg, drive_min_reg, deadband_reg;

    // sequencer
    logic [3:0]  pc_reg, pc_next;
    ctrl_word_t  cw;

    // tick inputs
    logic [15:0] sample_reg, sample_next;
    logic [15:0] supply_reg, supply_next;
    logic        txdis_reg, txdis_next;

    // loop state
    logic signed [16:0] err_reg, err_next;
    logic signed [19:0] error_sum_reg, error_sum_next;
    logic signed [14:0] last_error_reg, last_error_next;
    logic signed [14:0] prior_error_reg, prior_error_next;
    logic signed [15:0] d_reg, d_next;
    logic [CNT_W-1:0]   diverge_reg, diverge_next;
    logic [11:0]        held_code_reg, held_code_next;
    logic               enable_reg, enable_next;
    logic               evaluated_reg, evaluated_next;
    logic               wr_flag_reg, wr_flag_next;
    logic               st_flag_reg, st_flag_next;

    // datapath
    logic signed [37:0] prod_reg, prod_next;
    logic signed [37:0] acc_reg, acc_next;
    logic signed [26:0] level_reg, level_next;
    logic [15:0]        clamp_reg, clamp_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [15:0]        rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    // combinational helpers
    logic [15:0]        err_mag;
    logic               target_ok, skip_hit, inband, out_free;
    logic signed [14:0] e_clamp;
    logic signed [20:0] sum_wide;
    logic signed [19:0] sum_sat;
    logic [CNT_W-1:0]   diverge_inc;
    logic signed [37:0] acc_adj;
    logic signed [25:0] acc_q;
    logic signed [16:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [37:0] mul_full;
    logic [16:0]        rem_sh;
    logic               rem_ge;
    logic [11:0]        code_val;

    assign cw       = ucode_rom(pc_reg);
    assign s_tready = aresetn && (pc_reg == STEP_WAIT);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign err_mag   = err_reg[16] ? 16'(-err_reg) : err_reg[15:0];
    assign target_ok = (target_reg != 16'd0) && (target_reg < ENABLE_CEIL);
    assign skip_hit  = txdis_reg && enable_reg;
    assign inband    = (err_mag < deadband_reg);

    assign e_clamp  = (err_reg > ERR_HI) ? 15'(ERR_HI) :
                      (err_reg < ERR_LO) ? 15'(ERR_LO) : 15'(err_reg);
    assign sum_wide = $signed({error_sum_reg[19], error_sum_reg})
                    + $signed({{6{e_clamp[14]}}, e_clamp});
    assign sum_sat  = (sum_wide > SUM_HI) ? 20'(SUM_HI) :
                      (sum_wide < SUM_LO) ? 20'(SUM_LO) : 20'(sum_wide);
    assign diverge_inc = diverge_reg + CNT_W'(1);

    // truncate toward zero on the signed 38-bit q26.12 sum
    assign acc_adj = acc_reg + (acc_reg[37] ? TRUNC_BIAS : 38'sd0);
    assign acc_q   = acc_adj[37:12];

    assign mul_full = mul_a * mul_b;

    // one restoring step
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, supply_reg});

    assign code_val = (supply_reg == 16'd0) ? 12'(DAC_FULL) : 12'(dvd_reg[DAC_BITS-1:0]);

    always_comb begin
        case (cw.op)
            OP_MUL_P: begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = $signed({{6{last_error_reg[14]}}, last_error_reg});
            end
            OP_MUL_I: begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = $signed({error_sum_reg[19], error_sum_reg});
            end
            OP_MUL_D: begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = $signed({{5{d_reg[15]}}, d_reg});
            end
            OP_MUL_S: begin
                mul_a = $signed({1'b0, clamp_reg});
                mul_b = $signed(21'(DAC_FULL));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        case (cw.cond)
            COND_NONE:     pc_next = 4'(pc_reg + 4'd1);
            COND_NO_INPUT: pc_next = s_tvalid ? 4'(pc_reg + 4'd1) : cw.target;
            COND_SKIP:     pc_next = skip_hit ? cw.target : 4'(pc_reg + 4'd1);
            COND_INBAND:   pc_next = inband ? cw.target : 4'(pc_reg + 4'd1);
            COND_DIV_BUSY: pc_next = (dcnt_reg != DCNT_W'(1)) ? cw.target
                                                              : 4'(pc_reg + 4'd1);
            COND_WAIT_OUT: pc_next = out_free ? cw.target : pc_reg;
            default:       pc_next = STEP_WAIT;
        endcase
    end

    // datapath
    always_comb begin
        sample_next      = sample_reg;
        supply_next      = supply_reg;
        txdis_next       = txdis_reg;
        err_next         = err_reg;
        error_sum_next   = error_sum_reg;
        last_error_next  = last_error_reg;
        prior_error_next = prior_error_reg;
        d_next           = d_reg;
        diverge_next     = diverge_reg;
        held_code_next   = held_code_reg;
        enable_next      = enable_reg;
        evaluated_next   = evaluated_reg;
        wr_flag_next     = wr_flag_reg;
        st_flag_next     = st_flag_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        level_next       = level_reg;
        clamp_next       = clamp_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dcnt_next        = dcnt_reg;
        out_valid_next   = (out_valid_reg && !m_tready);
        out_data_next    = out_data_reg;

        case (cw.op)
            OP_LATCH: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[15:0];
                    supply_next = s_tdata[31:16];
                    txdis_next  = s_tdata[32];
                end
            end
            OP_EVAL: begin
                if (!evaluated_reg) begin
                    enable_next    = target_ok;
                    evaluated_next = 1'b1;
                end
                err_next = $signed({1'b0, target_reg}) - $signed({1'b0, sample_reg});
            end
            OP_SKIP: begin
                wr_flag_next = 1'b0;
                st_flag_next = 1'b1;
            end
            OP_BAND: begin
                wr_flag_next = 1'b0;
                st_flag_next = 1'b0;
            end
            OP_DIVERGE: begin
                wr_flag_next = 1'b1;
                st_flag_next = 1'b1;
                if (err_mag > DIVERGE_ERR) begin
                    if (diverge_inc > CNT_W'(DIVERGE_TICKS)) begin
                        error_sum_next   = '0;
                        last_error_next  = '0;
                        prior_error_next = '0;
                        diverge_next     = '0;
                        enable_next      = target_ok;
                    end else begin
                        diverge_next = diverge_inc;
                    end
                end else begin
                    diverge_next = '0;
                end
            end
            OP_INTEG: begin
                error_sum_next   = sum_sat;
                d_next           = $signed({last_error_reg[14], last_error_reg})
                                 - $signed({prior_error_reg[14], prior_error_reg});
                prior_error_next = last_error_reg;
                last_error_next  = e_clamp;
                acc_next         = '0;
            end
            OP_MUL_P: begin
                prod_next = mul_full;
            end
            OP_MUL_I, OP_MUL_D: begin
                prod_next = mul_full;
                acc_next  = acc_reg + prod_reg;
            end
            OP_ACC: begin
                acc_next = acc_reg + prod_reg;
            end
            OP_LEVEL: begin
                level_next = $signed({11'b0, balance_reg}) + $signed({acc_q[25], acc_q});
            end
            OP_CLAMP: begin
                if (level_reg > $signed({11'b0, drive_max_reg})) begin
                    clamp_next = drive_max_reg;
                end else if (level_reg < $signed({11'b0, drive_min_reg})) begin
                    clamp_next = drive_min_reg;
                end else begin
                    clamp_next = level_reg[15:0];
                end
            end
            OP_MUL_S: begin
                prod_next = mul_full;
            end
            OP_DIV_LOAD: begin
                dvd_next  = prod_reg[DVD_W-1:0];
                rem_next  = '0;
                dcnt_next = DCNT_W'(DVD_W);
            end
            OP_DIV: begin
                // quotient bits shift into the dividend register from the bottom
                rem_next  = rem_ge ? 16'(rem_sh - {1'b0, supply_reg}) : rem_sh[15:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], rem_ge};
                dcnt_next = dcnt_reg - DCNT_W'(1);
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (wr_flag_reg) begin
                        held_code_next = code_val;
                        out_data_next  = {1'b0, enable_reg, st_flag_reg, 1'b1, code_val};
                    end else begin
                        out_data_next  = {1'b0, enable_reg, st_flag_reg, 1'b0,
                                          held_code_reg};
                    end
                end
            end
            default: begin
                out_valid_next = (out_valid_reg && !m_tready);
            end
        endcase
    end

    // control and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= 16'd0;
            gain_p_reg      <= 16'd1229;
            gain_i_reg      <= 16'd41;
            gain_d_reg      <= 16'd410;
            balance_reg     <= 16'd12500;
            drive_max_reg   <= 16'd16500;
            drive_min_reg   <= 16'd8500;
            deadband_reg    <= 16'd50;
            pc_reg          <= STEP_WAIT;
            error_sum_reg   <= '0;
            last_error_reg  <= '0;
            prior_error_reg <= '0;
            diverge_reg     <= '0;
            held_code_reg   <= '0;
            enable_reg      <= 1'b0;
            evaluated_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET_TEMP:   target_reg    <= cfg_wdata;
                    REG_GAIN_P:        gain_p_reg    <= cfg_wdata;
                    REG_GAIN_I:        gain_i_reg    <= cfg_wdata;
                    REG_GAIN_D:        gain_d_reg    <= cfg_wdata;
                    REG_BALANCE_LEVEL: balance_reg   <= cfg_wdata;
                    REG_DRIVE_MAX:     drive_max_reg <= cfg_wdata;
                    REG_DRIVE_MIN:     drive_min_reg <= cfg_wdata;
                    REG_DEADBAND:      deadband_reg  <= cfg_wdata;
                    default:           deadband_reg  <= deadband_reg;
                endcase
            end
            pc_reg          <= pc_next;
            error_sum_reg   <= error_sum_next;
            last_error_reg  <= last_error_next;
            prior_error_reg <= prior_error_next;
            diverge_reg     <= diverge_next;
            held_code_reg   <= held_code_next;
            enable_reg      <= enable_next;
            evaluated_reg   <= evaluated_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        supply_reg   <= supply_next;
        txdis_reg    <= txdis_next;
        err_reg      <= err_next;
        d_reg        <= d_next;
        wr_flag_reg  <= wr_flag_next;
        st_flag_reg  <= st_flag_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        level_reg    <= level_next;
        clamp_reg    <= clamp_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: tb/sv/tb_tec_pid_drive_controller.sv
// testbench for the tec pid drive controller with a local loop predictor
`timescale 1ns / 1ps

module tb_tec_pid_drive_controller;
    import tpdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 50;

    // result fields, lowest bit last
    typedef struct packed {
        logic        cooler_en;
        logic        status;
        logic        written;
        logic [11:0] code;
    } drive_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    tec_pid_drive_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // loop state and register copy used for prediction
    logic [15:0]   reg_copy [0:7];
    int            integ_sum;
    int            err_now;
    int            err_prev;
    int unsigned   far_run;
    logic [11:0]   code_held;
    bit            enable_on;
    bit            enable_known;

    drive_result_t drive_expect_q[$];
    bit            no_idle;
    int            mismatches;
    int            ticks_sent, ticks_driven, ticks_on_target, ticks_held;
    int            reg_writes, enable_high, enable_low;
    int            idle_run;

    function automatic bit target_enables();
        return reg_copy[REG_TARGET_TEMP] > 16'd0 && reg_copy[REG_TARGET_TEMP] < ENABLE_CEIL;
    endfunction

    function automatic void reset_loop();
        integ_sum    = 0;
        err_now      = 0;
        err_prev     = 0;
        far_run      = 0;
        code_held    = '0;
        enable_on    = 1'b0;
        enable_known = 1'b0;
    endfunction

    function automatic drive_result_t next_drive(input logic [15:0] temp,
                                                 input logic [15:0] supply,
                                                 input logic tx_off);
        drive_result_t r;
        int     err, mag, e, d;
        longint acc, level, code;
        if (!enable_known) begin
            enable_on    = target_enables();
            enable_known = 1'b1;
        end
        if (tx_off && enable_on) begin
            r = '{enable_on, 1'b1, 1'b0, code_held};
            return r;
        end
        err = int'(reg_copy[REG_TARGET_TEMP]) - int'(temp);
        mag = err < 0 ? -err : err;
        if (mag < int'(reg_copy[REG_DEADBAND])) begin
            r = '{enable_on, 1'b0, 1'b0, code_held};
            return r;
        end
        if (mag > int'(DIVERGE_ERR)) begin
            far_run++;
            // runaway loop: start over and look at the set point again
            if (far_run > 20) begin
                integ_sum = 0;
                err_now   = 0;
                err_prev  = 0;
                far_run   = 0;
                enable_on = target_enables();
            end
        end else begin
            far_run = 0;
        end
        e = err > 10000 ? 10000 : (err < -10000 ? -10000 : err);
        integ_sum += e;
        if (integ_sum > 500000) integ_sum = 500000;
        if (integ_sum < -500000) integ_sum = -500000;
        d        = err_now - err_prev;
        err_prev = err_now;
        err_now  = e;
        acc = longint'(reg_copy[REG_GAIN_P]) * e + longint'(reg_copy[REG_GAIN_I]) * integ_sum
            + longint'(reg_copy[REG_GAIN_D]) * d;
        acc = acc / 4096;
        level = longint'(reg_copy[REG_BALANCE_LEVEL]) + acc;
        if (level > longint'(reg_copy[REG_DRIVE_MAX]))
            level = longint'(reg_copy[REG_DRIVE_MAX]);
        else if (level < longint'(reg_copy[REG_DRIVE_MIN]))
            level = longint'(reg_copy[REG_DRIVE_MIN]);
        if (supply == 16'd0) code = 4095;
        else code = ((level * 4095) / longint'(supply)) & 4095;
        code_held = code[11:0];
        r = '{enable_on, 1'b1, 1'b1, code_held};
        return r;
    endfunction

    function automatic logic [15:0] clip16(input int v);
        return v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : v[15:0]);
    endfunction

    // a sample at least 6001 counts away from the set point
    function automatic logic [15:0] far_temp(input int target);
        bit low_ok, high_ok;
        low_ok  = target >= 6001;
        high_ok = target <= 65535 - 6001;
        if (low_ok && (!high_ok || $urandom_range(0, 1) == 0))
            return 16'($urandom_range(0, target - 6001));
        return 16'($urandom_range(target + 6001, 65535));
    endfunction

    function automatic logic [15:0] pick_reg(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(lo, hi));
    endfunction

    function automatic logic [15:0] pick_supply();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom_range(1, 15));
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(1000, 65535));
    endfunction

    function automatic void flag_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_copy[idx] = val;
        reg_writes++;
    endtask

    task automatic load_regs(input logic [15:0] target, input logic [15:0] kp,
                             input logic [15:0] ki, input logic [15:0] kd,
                             input logic [15:0] bal, input logic [15:0] dmax,
                             input logic [15:0] dmin, input logic [15:0] dband);
        set_reg(REG_TARGET_TEMP, target);
        set_reg(REG_GAIN_P, kp);
        set_reg(REG_GAIN_I, ki);
        set_reg(REG_GAIN_D, kd);
        set_reg(REG_BALANCE_LEVEL, bal);
        set_reg(REG_DRIVE_MAX, dmax);
        set_reg(REG_DRIVE_MIN, dmin);
        set_reg(REG_DEADBAND, dband);
    endtask

    task automatic send_tick(input logic [15:0] temp, input logic [15:0] supply,
                             input logic tx_off);
        int gap;
        drive_result_t want;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tx_off, supply, temp};
        do @(posedge aclk); while (!s_tready);
        want = next_drive(temp, supply, tx_off);
        drive_expect_q.push_back(want);
        ticks_sent++;
        if (want.written) ticks_driven++;
        else if (!want.status) ticks_on_target++;
        else ticks_held++;
    endtask

    // stop offering items and let the block finish every tick in flight
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_first_tick();
        load_regs(16'd1000, 16'd1229, 16'd41, 16'd410, 16'd12500, 16'd16500, 16'd8500,
                  16'd50);
        send_tick(16'd1000, 16'd4000, 1'b0);    // first tick lands on target
        send_tick(16'd1000, 16'd4000, 1'b1);    // held while transmit is disabled
        send_tick(16'd0, 16'hFFFF, 1'b0);
        send_tick(16'hFFFF, 16'd1, 1'b0);
        send_tick(16'd1049, 16'd3300, 1'b0);    // just inside the deadband
        send_tick(16'd1050, 16'd3300, 1'b0);    // just outside
        send_tick(16'd500, 16'd0, 1'b0);        // zero supply saturates
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // drive_min above drive_max: the upper clamp wins
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_tick(16'd0, 16'hFFFF, 1'b0);
        send_tick(16'hFFFF, 16'd1, 1'b0);
        send_tick(16'd32768, 16'd3, 1'b1);
        send_tick(16'd100, 16'd0, 1'b0);
        wait_idle();
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_tick(16'hFFFF, 16'd100, 1'b0);
        send_tick(16'd1, 16'd777, 1'b0);
        send_tick(16'hFFFE, 16'd2, 1'b1);
        wait_idle();
        load_regs(16'd12000, 16'd1229, 16'd41, 16'd410, 16'd12500, 16'd16500, 16'd8500,
                  16'd50);
        send_tick(16'd11000, 16'd3300, 1'b0);
        send_tick(16'd13000, 16'd3300, 1'b0);
        send_tick(16'd12010, 16'd3300, 1'b0);
        wait_idle();
    endtask

    // long same-sign errors at or below the runaway threshold push the integral into its clamp
    task automatic test_integral_windup();
        int target, mag_e, err;
        bit up;
        for (int ph = 0; ph < 2; ph++) begin
            target  = $urandom_range(8000, 14000);
            no_idle = ($urandom_range(0, 3) == 0);
            up      = (ph == 0);
            load_regs(16'(target), 16'($urandom_range(0, 2000)), 16'($urandom_range(1, 200)),
                      16'($urandom_range(0, 2000)), 16'd12500, 16'hFFFF, 16'd0,
                      16'($urandom_range(0, 200)));
            for (int k = 0; k < 130; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick(16'($urandom_range(0, 65535)), pick_supply(),
                              1'($urandom_range(0, 1)));
                end else begin
                    mag_e = $urandom_range(5000, 6000);
                    err   = up ? mag_e : -mag_e;
                    send_tick(clip16(target - err), pick_supply(), 1'b0);
                end
            end
            wait_idle();
        end
    endtask

    // runs of large errors clear the loop and reevaluate the enable from the set point
    task automatic test_runaway_reset();
        int target, burst;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       target = ($urandom_range(0, 1) == 0) ? 19999 : $urandom_range(1, 19999);
                1:       target = 0;
                2:       target = ($urandom_range(0, 1) == 0) ? 20000 : $urandom_range(20000, 65535);
                default: target = 1;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            load_regs(16'(target), pick_reg(0, 4095), pick_reg(0, 400), pick_reg(0, 4095),
                      16'($urandom_range(0, 30000)), 16'($urandom_range(15000, 65535)),
                      16'($urandom_range(0, 15000)), 16'($urandom_range(0, 100)));
            for (int b = 0; b < 3; b++) begin
                burst = $urandom_range(18, 28);
                for (int k = 0; k < burst; k++)
                    send_tick(far_temp(target), pick_supply(), ($urandom_range(0, 7) == 0));
                repeat ($urandom_range(3, 6))
                    send_tick(clip16(target + 2000 - int'($urandom_range(0, 4000))),
                              pick_supply(), ($urandom_range(0, 7) == 0));
            end
            wait_idle();
        end
    endtask

    task automatic test_random_mix();
        int target, spread, band, err, r;
        for (int ph = 0; ph < 3; ph++) begin
            target  = int'(pick_reg(0, 30000));
            no_idle = ($urandom_range(0, 3) == 0);
            load_regs(16'(target), pick_reg(0, 8191), pick_reg(0, 1000), pick_reg(0, 8191),
                      pick_reg(0, 65535), pick_reg(0, 65535), pick_reg(0, 65535),
                      pick_reg(0, 300));
            spread = $urandom_range(0, 9000);
            band   = int'(reg_copy[REG_DEADBAND]);
            for (int k = 0; k < 110; k++) begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    err = int'($urandom_range(0, 2 * spread)) - spread;
                    send_tick(clip16(target - err), pick_supply(), ($urandom_range(0, 7) == 0));
                end else if (r < 6) begin
                    // right around the deadband edge
                    err = band - 1 + int'($urandom_range(0, 2));
                    if ($urandom_range(0, 1) == 1) err = -err;
                    send_tick(clip16(target - err), pick_supply(), ($urandom_range(0, 7) == 0));
                end else if (r < 8) begin
                    send_tick(16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535) | 32'd1),
                              1'($urandom_range(0, 1)));
                end else if (r == 8) begin
                    send_tick(($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF, pick_supply(),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_tick(far_temp(target), pick_supply(), ($urandom_range(0, 7) == 0));
                end
            end
            wait_idle();
        end
    endtask

    // result side: a random stall per item, held while the result waits
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        drive_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[14:0];
            if (got.cooler_en) enable_high++;
            else enable_low++;
            if (drive_expect_q.size() == 0) begin
                flag_failure($sformatf("result with nothing pending: %04h", m_tdata));
            end else begin
                want = drive_expect_q.pop_front();
                if (got.code !== want.code || got.written !== want.written
                    || got.status !== want.status || got.cooler_en !== want.cooler_en)
                    flag_failure($sformatf({"mismatch code exp %0d got %0d, written exp %0b ",
                        "got %0b, status exp %0b got %0b, enable exp %0b got %0b"},
                        want.code, got.code, want.written, got.written, want.status,
                        got.status, want.cooler_en, got.cooler_en));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run == WATCHDOG_LIMIT) begin
                $display("no item moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, drive_expect_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        no_idle   = 1'b0;
        idle_run  = 0;
        mismatches = 0;
        ticks_sent = 0; ticks_driven = 0; ticks_on_target = 0; ticks_held = 0;
        reg_writes = 0; enable_high = 0; enable_low = 0;
        reg_copy[REG_TARGET_TEMP]   = 16'd0;
        reg_copy[REG_GAIN_P]        = 16'd1229;
        reg_copy[REG_GAIN_I]        = 16'd41;
        reg_copy[REG_GAIN_D]        = 16'd410;
        reg_copy[REG_BALANCE_LEVEL] = 16'd12500;
        reg_copy[REG_DRIVE_MAX]     = 16'd16500;
        reg_copy[REG_DRIVE_MIN]     = 16'd8500;
        reg_copy[REG_DEADBAND]      = 16'd50;
        reset_loop();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_tick();
        test_register_extremes();
        test_integral_windup();
        test_runaway_reset();
        test_random_mix();

        s_tvalid <= 1'b0;
        for (int k = 0; k < SETTLE_CYCLES + 2000 && drive_expect_q.size() != 0; k++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (drive_expect_q.size() != 0)
            flag_failure($sformatf("%0d results never arrived", drive_expect_q.size()));

        $display("%0d ticks: %0d drove a new code, %0d on target, %0d held by transmit disable",
                 ticks_sent, ticks_driven, ticks_on_target, ticks_held);
        $display("%0d register writes; cooler enable high on %0d results, low on %0d",
                 reg_writes, enable_high, enable_low);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tpdc_pkg.sv
hw/rtl/tec_pid_drive_controller.sv
tb/sv/tb_tec_pid_drive_controller.sv
